// ----- design/first_fit_heap_allocator_top_defines.svh -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top_defines.svh
// Assertion macros used by the allocator checker.
// ----------------------------------------------------------------------------
`ifndef FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define FFHA_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ffha assertion failed");

// Next-cycle implication, clocked on clock, off during reset.
`define FFHA_ASSERT_NXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ffha assertion failed");

`endif

// ----- design/ffha_pkg.sv -----
// ----------------------------------------------------------------------------
// ffha_pkg
// Codes and types shared by the allocator cells, tables and sequencer.
// ----------------------------------------------------------------------------
package ffha_pkg;

   localparam int REQ_BYTES_W = 16;
   localparam int ADDR_W      = 12;
   localparam int WORDS_W     = 14;
   localparam int STATUS_W    = 2;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] ST_NOFIT   = 2'd1;
   localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_UNKNOWN = 2'd3;

   localparam logic [2:0] CELL_HOLD = 3'd0;
   localparam logic [2:0] CELL_LOAD = 3'd1;
   localparam logic [2:0] CELL_SHL  = 3'd2;
   localparam logic [2:0] CELL_MRG  = 3'd3;
   localparam logic [2:0] CELL_INS  = 3'd4;

   typedef struct packed {
      logic [2:0] op;
      logic       at_pos;
      logic       past_pos;
   } cell_ctl_type;

   typedef struct packed {
      logic touch;
      logic fit;
      logic match;
   } cell_flag_type;

endpackage

// ----- design/first_fit_heap_allocator_top.sv -----
// ----------------------------------------------------------------------------
// first_fit_heap_allocator_top
// First-fit word-heap allocator with sorted free and used chunk tables.
//
// channel  | handshake     | ports
// ---------+---------------+-------------------------------------------------
// request  | start / busy  | req_opcode, req_request_bytes, req_release_addr
// response | rsp_valid     | rsp_grant_addr, rsp_status
//
// One request at a time; the response shows in the cycle after the last step.
// A zero-size allocate answers in the cycle after its transfer. An allocate
// merges coalesced pairs one by one (up to TABLE_SLOTS-1) until a merge step
// finds no pair, then searches and updates; a failure stops after the search.
// A free searches and updates, and stops after the search on an unknown address
// or a full free table. Reset is synchronous; the response cannot be stalled.
// ----------------------------------------------------------------------------
module first_fit_heap_allocator_top #(
   parameter int HEAP_WORDS  = 4096,
   parameter int TABLE_SLOTS = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [ffha_pkg::REQ_BYTES_W-1:0]    req_request_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]         req_release_addr,
   output logic                                rsp_valid,
   output logic [ffha_pkg::ADDR_W-1:0]         rsp_grant_addr,
   output logic [ffha_pkg::STATUS_W-1:0]       rsp_status
);

   localparam int AW = $clog2(HEAP_WORDS);
   localparam int LW = $clog2(HEAP_WORDS + 1);
   localparam int CW = (LW > ffha_pkg::WORDS_W) ? LW : ffha_pkg::WORDS_W;
   localparam int IW = $clog2(TABLE_SLOTS);
   localparam int WW = ffha_pkg::WORDS_W;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_MERGE  = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_APPLY  = 2'd3;

   logic [1:0]                      state_ff, state_in;
   logic                            op_ff, op_in;
   logic [WW-1:0]                   words_ff, words_in;
   logic [ffha_pkg::ADDR_W-1:0]     addr_ff, addr_in;
   logic [IW-1:0]                   idx_ff, idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [ffha_pkg::ADDR_W-1:0]     grant_ff, grant_in;
   logic [ffha_pkg::STATUS_W-1:0]   status_ff, status_in;

   logic [ffha_pkg::REQ_BYTES_W:0]  bytes_up;
   logic [WW-1:0]                   req_words;

   logic [2:0]             f_op, u_op;
   logic [IW-1:0]          f_pos, u_pos;
   logic [AW-1:0]          f_new_start, u_new_start, f_rd_start, u_rd_start;
   logic [LW-1:0]          f_new_len, u_new_len, f_rd_len, u_rd_len;
   logic [TABLE_SLOTS-1:0] f_valid, f_touch, f_fit, f_match;
   logic [TABLE_SLOTS-1:0] u_valid, u_touch, u_fit, u_match;
   logic [TABLE_SLOTS-1:0] sel_vec;
   logic [IW-1:0]          first_touch, first_sel;
   logic [LW-1:0]          rest;
   logic [CW-1:0]          grant_ext;

   function automatic logic [IW-1:0] first_set(input logic [TABLE_SLOTS-1:0] v);
      logic [IW-1:0] idx;
      idx = '0;
      for (int j = TABLE_SLOTS - 1; j >= 0; j--) begin
         if (v[j]) begin
            idx = IW'(j);
         end
      end
      return idx;
   endfunction

   assign bytes_up  = (ffha_pkg::REQ_BYTES_W+1)'(req_request_bytes) +
                      (ffha_pkg::REQ_BYTES_W+1)'(7);
   assign req_words = bytes_up[ffha_pkg::REQ_BYTES_W:3];

   assign sel_vec     = (op_ff == ffha_pkg::OP_ALLOC) ? f_fit : u_match;
   assign first_touch = first_set(f_touch);
   assign first_sel   = first_set(sel_vec);
   assign rest        = f_rd_len - LW'(words_ff);
   assign grant_ext   = CW'(f_rd_start);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      words_in     = words_ff;
      addr_in      = addr_ff;
      idx_in       = idx_ff;
      rsp_valid_in = 1'b0;
      grant_in     = grant_ff;
      status_in    = status_ff;
      f_op         = ffha_pkg::CELL_HOLD;
      u_op         = ffha_pkg::CELL_HOLD;
      f_pos        = idx_ff;
      u_pos        = idx_ff;
      f_new_start  = f_rd_start + AW'(words_ff);
      f_new_len    = rest;
      u_new_start  = f_rd_start;
      u_new_len    = LW'(words_ff);
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_opcode;
               words_in = req_words;
               addr_in  = req_release_addr;
               if (req_opcode == ffha_pkg::OP_FREE) begin
                  state_in = S_SEARCH;
               end else if (req_words == '0) begin
                  rsp_valid_in = 1'b1;
                  grant_in     = '0;
                  status_in    = ffha_pkg::ST_NOFIT;
               end else begin
                  state_in = S_MERGE;
               end
            end
         end
         S_MERGE: begin
            if (|f_touch) begin
               f_op  = ffha_pkg::CELL_MRG;
               f_pos = first_touch;
            end else begin
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            grant_in = '0;
            if (!(|sel_vec)) begin
               rsp_valid_in = 1'b1;
               status_in    = (op_ff == ffha_pkg::OP_ALLOC) ? ffha_pkg::ST_NOFIT
                                                             : ffha_pkg::ST_UNKNOWN;
               state_in     = S_IDLE;
            end else if ((op_ff == ffha_pkg::OP_ALLOC && u_valid[TABLE_SLOTS-1]) ||
                         (op_ff == ffha_pkg::OP_FREE && f_valid[TABLE_SLOTS-1])) begin
               rsp_valid_in = 1'b1;
               status_in    = ffha_pkg::ST_FULL;
               state_in     = S_IDLE;
            end else begin
               idx_in   = first_sel;
               state_in = S_APPLY;
            end
         end
         S_APPLY: begin
            rsp_valid_in = 1'b1;
            status_in    = ffha_pkg::ST_OK;
            state_in     = S_IDLE;
            if (op_ff == ffha_pkg::OP_ALLOC) begin
               f_op     = (rest != '0) ? ffha_pkg::CELL_LOAD : ffha_pkg::CELL_SHL;
               u_op     = ffha_pkg::CELL_INS;
               grant_in = grant_ext[ffha_pkg::ADDR_W-1:0];
            end else begin
               f_op        = ffha_pkg::CELL_INS;
               f_new_start = u_rd_start;
               f_new_len   = u_rd_len;
               u_op        = ffha_pkg::CELL_SHL;
               grant_in    = '0;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      words_ff  <= words_in;
      addr_ff   <= addr_in;
      idx_ff    <= idx_in;
      grant_ff  <= grant_in;
      status_ff <= status_in;
   end

   ffha_table #(
      .SLOTS      (TABLE_SLOTS),
      .AW         (AW),
      .LW         (LW),
      .CW         (CW),
      .RST_VALID0 (1'b1),
      .RST_LEN0   (HEAP_WORDS)
   ) u_free (
      .clock     (clock),
      .reset     (reset),
      .op        (f_op),
      .pos       (f_pos),
      .key       (CW'(words_ff)),
      .new_start (f_new_start),
      .new_len   (f_new_len),
      .rd_idx    (idx_ff),
      .rd_start  (f_rd_start),
      .rd_len    (f_rd_len),
      .valid_vec (f_valid),
      .touch_vec (f_touch),
      .fit_vec   (f_fit),
      .match_vec (f_match)
   );

   ffha_table #(
      .SLOTS      (TABLE_SLOTS),
      .AW         (AW),
      .LW         (LW),
      .CW         (CW),
      .RST_VALID0 (1'b0),
      .RST_LEN0   (0)
   ) u_used (
      .clock     (clock),
      .reset     (reset),
      .op        (u_op),
      .pos       (u_pos),
      .key       (CW'(addr_ff)),
      .new_start (u_new_start),
      .new_len   (u_new_len),
      .rd_idx    (idx_ff),
      .rd_start  (u_rd_start),
      .rd_len    (u_rd_len),
      .valid_vec (u_valid),
      .touch_vec (u_touch),
      .fit_vec   (u_fit),
      .match_vec (u_match)
   );

   assign busy           = (state_ff != S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_grant_addr = grant_ff;
   assign rsp_status     = status_ff;

endmodule

// ----- design/ffha_cell.sv -----
// ----------------------------------------------------------------------------
// ffha_cell
// One table slot: holds a chunk, shifts with its neighbors, raises flags.
// ----------------------------------------------------------------------------
module ffha_cell #(
   parameter int          AW        = 12,
   parameter int          LW        = 13,
   parameter int          CW        = 14,
   parameter bit          RST_VALID = 1'b0,
   parameter int unsigned RST_LEN   = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ffha_pkg::cell_ctl_type ctl,
   input  logic [CW-1:0]          key,
   input  logic [AW-1:0]          new_start,
   input  logic [LW-1:0]          new_len,
   input  logic                   prev_valid,
   input  logic [AW-1:0]          prev_start,
   input  logic [LW-1:0]          prev_len,
   input  logic                   next_valid,
   input  logic [AW-1:0]          next_start,
   input  logic [LW-1:0]          next_len,
   output logic                   valid,
   output logic [AW-1:0]          start,
   output logic [LW-1:0]          len,
   output ffha_pkg::cell_flag_type flag
);

   logic          valid_ff, valid_in;
   logic [AW-1:0] start_ff, start_in;
   logic [LW-1:0] len_ff, len_in;
   logic          gt_self, gt_prev;

   assign gt_self = valid_ff && (start_ff > new_start);
   assign gt_prev = prev_valid && (prev_start > new_start);

   always_comb begin
      valid_in = valid_ff;
      start_in = start_ff;
      len_in   = len_ff;
      case (ctl.op)
         ffha_pkg::CELL_LOAD: begin
            if (ctl.at_pos) begin
               start_in = new_start;
               len_in   = new_len;
            end
         end
         ffha_pkg::CELL_SHL: begin
            if (ctl.at_pos || ctl.past_pos) begin
               valid_in = next_valid;
               start_in = next_start;
               len_in   = next_len;
            end
         end
         ffha_pkg::CELL_MRG: begin
            if (ctl.at_pos) begin
               len_in = len_ff + next_len;
            end else if (ctl.past_pos) begin
               valid_in = next_valid;
               start_in = next_start;
               len_in   = next_len;
            end
         end
         ffha_pkg::CELL_INS: begin
            if (gt_prev) begin
               valid_in = prev_valid;
               start_in = prev_start;
               len_in   = prev_len;
            end else if (prev_valid && (gt_self || !valid_ff)) begin
               valid_in = 1'b1;
               start_in = new_start;
               len_in   = new_len;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= RST_VALID;
         start_ff <= '0;
         len_ff   <= LW'(RST_LEN);
      end else begin
         valid_ff <= valid_in;
         start_ff <= start_in;
         len_ff   <= len_in;
      end
   end

   assign valid = valid_ff;
   assign start = start_ff;
   assign len   = len_ff;

   assign flag.touch = valid_ff && next_valid &&
                       ((AW+LW+1)'(start_ff) + (AW+LW+1)'(len_ff) ==
                        (AW+LW+1)'(next_start));
   assign flag.fit   = valid_ff && (CW'(len_ff) >= key);
   assign flag.match = valid_ff && (CW'(start_ff) == key);

endmodule

// ----- design/ffha_table.sv -----
// ----------------------------------------------------------------------------
// ffha_table
// Address-sorted chunk table built as a row of cells with one read port.
// ----------------------------------------------------------------------------
module ffha_table #(
   parameter int          SLOTS      = 64,
   parameter int          AW         = 12,
   parameter int          LW         = 13,
   parameter int          CW         = 14,
   parameter bit          RST_VALID0 = 1'b0,
   parameter int unsigned RST_LEN0   = 0,
   localparam int         IW         = $clog2(SLOTS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [2:0]        op,
   input  logic [IW-1:0]     pos,
   input  logic [CW-1:0]     key,
   input  logic [AW-1:0]     new_start,
   input  logic [LW-1:0]     new_len,
   input  logic [IW-1:0]     rd_idx,
   output logic [AW-1:0]     rd_start,
   output logic [LW-1:0]     rd_len,
   output logic [SLOTS-1:0]  valid_vec,
   output logic [SLOTS-1:0]  touch_vec,
   output logic [SLOTS-1:0]  fit_vec,
   output logic [SLOTS-1:0]  match_vec
);

   logic [AW-1:0] start_w [SLOTS];
   logic [LW-1:0] len_w   [SLOTS];

   for (genvar j = 0; j < SLOTS; j++) begin : g_cell
      ffha_pkg::cell_ctl_type  ctl;
      ffha_pkg::cell_flag_type flag;
      logic                    pv, nv;
      logic [AW-1:0]           ps, ns;
      logic [LW-1:0]           pl, nl;

      assign ctl.op       = op;
      assign ctl.at_pos   = (IW'(j) == pos);
      assign ctl.past_pos = (IW'(j) > pos);

      if (j == 0) begin : g_first
         assign pv = 1'b1;
         assign ps = '0;
         assign pl = '0;
      end else begin : g_mid
         assign pv = valid_vec[j-1];
         assign ps = start_w[j-1];
         assign pl = len_w[j-1];
      end

      if (j == SLOTS-1) begin : g_last
         assign nv = 1'b0;
         assign ns = '0;
         assign nl = '0;
      end else begin : g_inner
         assign nv = valid_vec[j+1];
         assign ns = start_w[j+1];
         assign nl = len_w[j+1];
      end

      ffha_cell #(
         .AW        (AW),
         .LW        (LW),
         .CW        (CW),
         .RST_VALID ((j == 0) ? RST_VALID0 : 1'b0),
         .RST_LEN   ((j == 0) ? RST_LEN0 : 0)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctl        (ctl),
         .key        (key),
         .new_start  (new_start),
         .new_len    (new_len),
         .prev_valid (pv),
         .prev_start (ps),
         .prev_len   (pl),
         .next_valid (nv),
         .next_start (ns),
         .next_len   (nl),
         .valid      (valid_vec[j]),
         .start      (start_w[j]),
         .len        (len_w[j]),
         .flag       (flag)
      );

      assign touch_vec[j] = flag.touch;
      assign fit_vec[j]   = flag.fit;
      assign match_vec[j] = flag.match;
   end

   assign rd_start = start_w[rd_idx];
   assign rd_len   = len_w[rd_idx];

endmodule

// ----- design/ffha_checker.sv -----
// ----------------------------------------------------------------------------
// ffha_checker
// Port-level checks on the allocator's request and response behavior.
// ----------------------------------------------------------------------------
`include "first_fit_heap_allocator_top_defines.svh"

module ffha_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              start,
   input logic                              busy,
   input logic                              rsp_valid,
   input logic [ffha_pkg::ADDR_W-1:0]       rsp_grant_addr,
   input logic [ffha_pkg::STATUS_W-1:0]     rsp_status
);

   `FFHA_ASSERT_NOW(a_rsp_idle, rsp_valid, !busy)
   `FFHA_ASSERT_NXT(a_accept_progress, start && !busy, busy || rsp_valid)
   `FFHA_ASSERT_NOW(a_fail_grant_zero, rsp_valid && rsp_status != ffha_pkg::ST_OK, rsp_grant_addr == '0)

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (.*);
